>>> hdl/stbc_pkg.sv
package stbc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_PAIRS    = 512;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Pilot amplitude, 1.0 in Q2.14
  localparam sample_t PILOT_ONE  = sample_t'(1 << (SAMPLE_WIDTH - 2));
  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(1 << (SAMPLE_WIDTH - 1));

  // Scrambler seeds per FFT mode
  localparam logic [6:0] SEED_SMALL = 7'h78;
  localparam logic [6:0] SEED_LARGE = 7'h70;
  localparam logic [6:0] SCRAM_MASK = 7'h7E;

  // Subcarriers per symbol, minus one
  localparam logic [7:0] LAST_SC_SMALL = 8'd55;
  localparam logic [7:0] LAST_SC_LARGE = 8'd241;

  localparam logic [9:0] PAIRS_CAP = 10'(MAX_PAIRS);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FFT_MODE     = 2'd0,
    REG_SYMBOL_PAIRS = 2'd1,
    REG_UE_SELECT    = 2'd2
  } reg_index_t;

  typedef struct packed {
    sample_t s0_re;
    sample_t s0_im;
    sample_t s1_re;
    sample_t s1_im;
  } in_word_t;

  typedef struct packed {
    logic    slot;
    sample_t ant0_re;
    sample_t ant0_im;
    sample_t ant1_re;
    sample_t ant1_im;
    logic    is_pilot;
    logic    last;
  } out_word_t;

  // Control carried with a word from the input register to the result stage
  typedef struct packed {
    logic       pilot;
    logic [1:0] on;     // per slot: pilot carries energy
    logic [1:0] neg0;   // per slot: antenna 0 pilot is negative
    logic [1:0] neg1;   // per slot: antenna 1 pilot is negative
    logic       last;
  } pilot_ctl_t;

  // Pilot subcarrier position for pilot number k
  function automatic logic [7:0] pilot_pos(input logic mode, input logic [2:0] k);
    logic [7:0] p;
    if (mode) begin
      case (k)
        3'd0:    p = 8'd6;
        3'd1:    p = 8'd32;
        3'd2:    p = 8'd74;
        3'd3:    p = 8'd100;
        3'd4:    p = 8'd141;
        3'd5:    p = 8'd167;
        3'd6:    p = 8'd209;
        default: p = 8'd235;
      endcase
    end else begin
      case (k[1:0])
        2'd0:    p = 8'd7;
        2'd1:    p = 8'd21;
        2'd2:    p = 8'd34;
        default: p = 8'd48;
      endcase
    end
    return p;
  endfunction

  // Base pilot sign (1 = negative) for antenna 0
  function automatic logic base_neg0(input logic mode, input logic [2:0] idx);
    logic n;
    if (mode) n = (idx == 3'd3) || (idx == 3'd4);
    else      n = idx[1];
    return n;
  endfunction

  // Base pilot sign (1 = negative) for antenna 1
  function automatic logic base_neg1(input logic mode, input logic [2:0] idx);
    logic n;
    if (mode) n = (idx == 3'd3) || (idx == 3'd4);
    else      n = idx[1] ^ idx[0];
    return n;
  endfunction

  function automatic sample_t neg_sat(input sample_t x);
    sample_t r;
    if (x == SAMPLE_MIN) r = SAMPLE_MAX;
    else                 r = -x;
    return r;
  endfunction

  function automatic sample_t pilot_value(input logic on, input logic neg);
    sample_t v;
    if (!on)      v = '0;
    else if (neg) v = -PILOT_ONE;
    else          v = PILOT_ONE;
    return v;
  endfunction

endpackage

>>> hdl/alamouti_stbc_pilot_encoder_top.sv
// Alamouti 2x1 encoder with pilot insertion. Each input word holds the two
// Q2.14 samples (even and odd OFDM symbol) of one subcarrier; the block returns
// two output words for it, slot 0 (ant0 = s0, ant1 = s1) then slot 1
// (ant0 = -conj(s1), ant1 = conj(s0)), with the pilot subcarriers replaced by
// +-1.0 or zero. Input words are taken in subcarrier order within a pair and
// pair after pair; the packet restarts after the last pair and on any
// register write. One output channel carries two words per input word, so a
// new word waits in the input register until the last slot 1 word is taken.
// The slot 0 word passes the input register, then the result register.
module alamouti_stbc_pilot_encoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  stbc_pkg::in_word_t  sample,
  output logic                result_valid,
  input  logic                result_stall,
  output stbc_pkg::out_word_t result
);
  import stbc_pkg::*;

  // Configuration
  logic              fft_mode;
  logic [9:0]        symbol_pairs;
  logic signed [4:0] ue_select;

  // Packet state
  logic [6:0] scrambler;
  logic [7:0] sc_count;
  logic [8:0] pair_count;
  logic [2:0] pilot_pos_q;
  logic [1:0] pair_par;

  // Input register stage
  logic       s1_valid;
  in_word_t   s1_word;
  pilot_ctl_t s1_ctl;

  // Result register stage
  logic      out_valid;
  out_word_t out_word;
  logic      odd_valid;
  out_word_t odd_word;

  logic accept, out_take, load;

  assign out_take     = out_valid & ~result_stall;
  assign load         = s1_valid & (~out_valid | (out_take & ~odd_valid));
  assign sample_stall = s1_valid & ~load;
  assign accept       = sample_valid & ~sample_stall;
  assign result_valid = out_valid;
  assign result       = out_word;

  // Per-word control from the packet counters
  logic [6:0] scram_next;
  logic       p_even, p_odd;
  logic       sc_first;
  logic [2:0] pp_eff;
  logic [1:0] par_eff;
  logic       pilot_hit;
  logic [2:0] idx_mask;
  logic [2:0] idx0, idx1;
  logic [1:0] on_s;
  logic [9:0] pairs_eff;
  logic       sc_end, pair_end, last_word;
  pilot_ctl_t ctl_next;

  always_comb begin
    // two scrambler steps, one per OFDM symbol of the pair
    p_even     = scrambler[6] ^ scrambler[3];
    p_odd      = scrambler[5] ^ scrambler[2];
    scram_next = (({scrambler[5:0], p_even} << 1) & SCRAM_MASK) | {6'd0, p_odd};
    sc_first   = (sc_count == 8'd0);
    pp_eff     = sc_first ? 3'd0 : pilot_pos_q;
    par_eff    = sc_first ? {p_odd, p_even} : pair_par;
    pilot_hit  = (fft_mode | ~pp_eff[2]) && (sc_count == pilot_pos(fft_mode, pp_eff));
    idx_mask   = fft_mode ? 3'd7 : 3'd3;
    idx0       = ({pair_count[1:0], 1'b0} + pp_eff) & idx_mask;
    idx1       = ({pair_count[1:0], 1'b1} + pp_eff) & idx_mask;
    on_s[0]    = ue_select[4] | (ue_select == 5'sd0);
    on_s[1]    = ue_select[4] | (ue_select == 5'sd1);

    if (symbol_pairs == 10'd0)        pairs_eff = 10'd1;
    else if (symbol_pairs > PAIRS_CAP) pairs_eff = PAIRS_CAP;
    else                               pairs_eff = symbol_pairs;
    sc_end    = sc_count >= (fft_mode ? LAST_SC_LARGE : LAST_SC_SMALL);
    pair_end  = ({1'b0, pair_count} + 10'd1) >= pairs_eff;
    last_word = sc_end & pair_end;

    ctl_next.pilot = pilot_hit;
    ctl_next.on    = on_s;
    ctl_next.neg0  = {par_eff[1] ^ base_neg0(fft_mode, idx1),
                      par_eff[0] ^ base_neg0(fft_mode, idx0)};
    ctl_next.neg1  = {par_eff[1] ^ base_neg1(fft_mode, idx1),
                      par_eff[0] ^ base_neg1(fft_mode, idx0)};
    ctl_next.last  = last_word;
  end

  // Configuration and packet counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fft_mode     <= 1'b0;
      symbol_pairs <= 10'd1;
      ue_select    <= -5'sd1;
      scrambler    <= SEED_SMALL;
      sc_count     <= '0;
      pair_count   <= '0;
      pilot_pos_q  <= '0;
      pair_par     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FFT_MODE: begin
          fft_mode  <= cfg_data[0];
          scrambler <= cfg_data[0] ? SEED_LARGE : SEED_SMALL;
        end
        REG_SYMBOL_PAIRS: begin
          symbol_pairs <= cfg_data;
          scrambler    <= fft_mode ? SEED_LARGE : SEED_SMALL;
        end
        REG_UE_SELECT: begin
          ue_select <= cfg_data[4:0];
          scrambler <= fft_mode ? SEED_LARGE : SEED_SMALL;
        end
        default: ;
      endcase
      if (cfg_index == REG_FFT_MODE || cfg_index == REG_SYMBOL_PAIRS ||
          cfg_index == REG_UE_SELECT) begin
        sc_count    <= '0;
        pair_count  <= '0;
        pilot_pos_q <= '0;
        pair_par    <= '0;
      end
    end else if (accept) begin
      if (last_word) begin
        scrambler   <= fft_mode ? SEED_LARGE : SEED_SMALL;
        sc_count    <= '0;
        pair_count  <= '0;
        pilot_pos_q <= '0;
        pair_par    <= '0;
      end else begin
        if (sc_first) scrambler <= scram_next;
        pair_par    <= par_eff;
        pilot_pos_q <= pilot_hit ? pp_eff + 3'd1 : pp_eff;
        if (sc_end) begin
          sc_count   <= '0;
          pair_count <= pair_count + 9'd1;
        end else begin
          sc_count <= sc_count + 8'd1;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= sample;
      s1_ctl  <= ctl_next;
    end
  end

  // Encode both slots
  out_word_t even_next, oddw_next;

  always_comb begin
    even_next.slot     = 1'b0;
    even_next.is_pilot = s1_ctl.pilot;
    even_next.last     = 1'b0;
    oddw_next.slot     = 1'b1;
    oddw_next.is_pilot = s1_ctl.pilot;
    oddw_next.last     = s1_ctl.last;
    if (s1_ctl.pilot) begin
      even_next.ant0_re = pilot_value(s1_ctl.on[0], s1_ctl.neg0[0]);
      even_next.ant0_im = '0;
      even_next.ant1_re = pilot_value(s1_ctl.on[0], s1_ctl.neg1[0]);
      even_next.ant1_im = '0;
      oddw_next.ant0_re = pilot_value(s1_ctl.on[1], s1_ctl.neg0[1]);
      oddw_next.ant0_im = '0;
      oddw_next.ant1_re = pilot_value(s1_ctl.on[1], s1_ctl.neg1[1]);
      oddw_next.ant1_im = '0;
    end else begin
      even_next.ant0_re = s1_word.s0_re;
      even_next.ant0_im = s1_word.s0_im;
      even_next.ant1_re = s1_word.s1_re;
      even_next.ant1_im = s1_word.s1_im;
      oddw_next.ant0_re = neg_sat(s1_word.s1_re);
      oddw_next.ant0_im = s1_word.s1_im;
      oddw_next.ant1_re = s1_word.s0_re;
      oddw_next.ant1_im = neg_sat(s1_word.s0_im);
    end
  end

  // Result register: slot 0 word shown, slot 1 word held behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      odd_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      odd_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= odd_valid;
      odd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= even_next;
      odd_word <= oddw_next;
    end else if (out_take && odd_valid) begin
      out_word <= odd_word;
    end
  end

  // Checks
  a_odd_behind_out: assert property (@(posedge clk) disable iff (rst)
    odd_valid |-> out_valid)
    else $error("slot 1 word held without slot 0 word");

  a_last_on_odd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.last) |-> out_word.slot)
    else $error("last flag on slot 0 word");

  a_odd_follows: assert property (@(posedge clk) disable iff (rst)
    (out_take && !out_word.slot) |=> (out_valid && out_word.slot))
    else $error("slot 1 word did not follow slot 0 word");

  a_slot_pilot_match: assert property (@(posedge clk) disable iff (rst)
    (out_take && !out_word.slot) |=> (out_word.is_pilot == $past(out_word.is_pilot)))
    else $error("pilot flag differs between slots of one word");

endmodule

>>> tb/tb.sv
module tb;
  import stbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_index    = '0;
  logic [9:0] cfg_data     = '0;
  logic       sample_valid = 1'b0;
  logic       sample_stall;
  in_word_t   sample       = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_word_t  result;

  // Encoder model state: register copies and packet counters
  logic       enc_large;
  logic [9:0] enc_pairs;
  logic [4:0] enc_ue;
  logic [6:0] scram;
  logic [1:0] sym_parity;
  int         sc_idx;
  int         pair_idx;
  int         pilot_k;

  int pos_small[4]   = '{7, 21, 34, 48};
  int pos_large[8]   = '{6, 32, 74, 100, 141, 167, 209, 235};
  int sign_small0[4] = '{1, 1, -1, -1};
  int sign_small1[4] = '{1, -1, -1, 1};
  int sign_large[8]  = '{1, 1, 1, -1, -1, 1, 1, 1};

  in_word_t  pending_words[$];
  out_word_t expected_words[$];

  int errors    = 0;
  int words_in  = 0;
  int words_out = 0;
  int settings  = 0;
  int quiet     = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit hold_go   = 1'b0;
  bit no_gaps   = 1'b0;

  alamouti_stbc_pilot_encoder_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void packet_restart();
    scram      = enc_large ? 7'h70 : 7'h78;
    sc_idx     = 0;
    pair_idx   = 0;
    pilot_k    = 0;
    sym_parity = 2'b00;
  endfunction

  // One LFSR step, returns the feedback bit as the symbol parity
  function automatic logic scramble_bit();
    logic fb;
    fb    = scram[6] ^ scram[3];
    scram = {scram[5:0], fb};
    return fb;
  endfunction

  function automatic sample_t negate_clip(input sample_t x);
    sample_t r;
    if (x == SAMPLE_MIN) r = SAMPLE_MAX;
    else                 r = -x;
    return r;
  endfunction

  // Expected slot 0 and slot 1 words for one subcarrier word
  function automatic void encode_pair(input in_word_t w);
    out_word_t o[2];
    int        nsc;
    int        npt;
    int        pairs;
    int        idx;
    int        sgn;
    int        b0;
    int        b1;
    logic      pilot;
    logic      on;
    logic      last_pair;
    nsc   = enc_large ? 242 : 56;
    npt   = enc_large ? 8 : 4;
    pairs = (enc_pairs == 0) ? 1 : ((enc_pairs > 512) ? 512 : int'(enc_pairs));
    if (sc_idx == 0) begin
      sym_parity[0] = scramble_bit();
      sym_parity[1] = scramble_bit();
      pilot_k       = 0;
    end
    o[0] = '0;
    o[1] = '0;
    o[0].ant0_re = w.s0_re;
    o[0].ant0_im = w.s0_im;
    o[0].ant1_re = w.s1_re;
    o[0].ant1_im = w.s1_im;
    o[1].slot    = 1'b1;
    o[1].ant0_re = negate_clip(w.s1_re);
    o[1].ant0_im = w.s1_im;
    o[1].ant1_re = w.s0_re;
    o[1].ant1_im = negate_clip(w.s0_im);
    pilot = 1'b0;
    if (pilot_k < npt)
      pilot = (sc_idx == (enc_large ? pos_large[pilot_k] : pos_small[pilot_k]));
    // Pilot subcarrier: base sign rotated by symbol index, times scrambler parity
    if (pilot) begin
      for (int s = 0; s < 2; s++) begin
        idx = (2 * pair_idx + s + pilot_k) & (npt - 1);
        sgn = sym_parity[s] ? -1 : 1;
        b0  = enc_large ? sign_large[idx] : sign_small0[idx];
        b1  = enc_large ? sign_large[idx] : sign_small1[idx];
        on  = enc_ue[4] || (enc_ue == 5'(s));
        o[s].ant0_re  = on ? sample_t'(sgn * b0 * 16384) : sample_t'(0);
        o[s].ant0_im  = sample_t'(0);
        o[s].ant1_re  = on ? sample_t'(sgn * b1 * 16384) : sample_t'(0);
        o[s].ant1_im  = sample_t'(0);
        o[s].is_pilot = 1'b1;
      end
      pilot_k = (pilot_k + 1) & 7;
    end
    last_pair = (sc_idx + 1 >= nsc) && (pair_idx + 1 >= pairs);
    o[1].last = last_pair;
    expected_words.push_back(o[0]);
    expected_words.push_back(o[1]);
    if (last_pair) packet_restart();
    else if (sc_idx + 1 >= nsc) begin
      sc_idx = 0;
      pair_idx++;
    end else sc_idx++;
  endfunction

  // Mostly random, with frequent full-scale and zero values
  function automatic sample_t rand_sample();
    sample_t v;
    case ($urandom_range(7))
      0:       v = SAMPLE_MIN;
      1:       v = SAMPLE_MAX;
      2:       v = sample_t'(0);
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic field_error(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
    end else begin
      want = expected_words.pop_front();
      words_out++;
      if (got.slot !== want.slot)         field_error("slot", want.slot, got.slot);
      if (got.ant0_re !== want.ant0_re)   field_error("ant0_re", want.ant0_re, got.ant0_re);
      if (got.ant0_im !== want.ant0_im)   field_error("ant0_im", want.ant0_im, got.ant0_im);
      if (got.ant1_re !== want.ant1_re)   field_error("ant1_re", want.ant1_re, got.ant1_re);
      if (got.ant1_im !== want.ant1_im)   field_error("ant1_im", want.ant1_im, got.ant1_im);
      if (got.is_pilot !== want.is_pilot) field_error("is_pilot", want.is_pilot, got.is_pilot);
      if (got.last !== want.last)         field_error("last", want.last, got.last);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FFT_MODE:     enc_large = val[0];
      REG_SYMBOL_PAIRS: enc_pairs = val;
      REG_UE_SELECT:    enc_ue    = val[4:0];
      default: ;
    endcase
    packet_restart();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word is sent and every result has come back
  task automatic drain();
    while (pending_words.size() != 0 || sample_valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input logic mode, input logic [9:0] pairs,
                           input logic [9:0] ue, input int count,
                           input bit steady, input bit hold);
    in_word_t w;
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_FFT_MODE, {9'd0, mode});
    write_reg(REG_SYMBOL_PAIRS, pairs);
    write_reg(REG_UE_SELECT, ue);
    settings++;
    @(negedge clk);
    no_gaps = steady;
    hold_go = hold;
    repeat (count) begin
      w.s0_re = rand_sample();
      w.s0_im = rand_sample();
      w.s1_re = rand_sample();
      w.s1_im = rand_sample();
      pending_words.push_back(w);
    end
  endtask

  // Sender: offers queued words, with random gaps unless no_gaps is set
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        encode_pair(sample);
        words_in++;
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_words.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
          sample       <= pending_words.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks accepted words, random stalls unless no_gaps is set, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_word(result);
      if (hold_go && !hold_done) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_gaps && ($urandom_range(99) < 21);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    in_word_t w;
    enc_large = 1'b0;
    enc_pairs = 10'd1;
    enc_ue    = 5'h1F;
    packet_restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed words at reset settings; subcarriers 7 and 21 are pilots
    for (int i = 0; i < 25; i++) begin
      case (i % 8)
        0: w = {SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
        1: w = {SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
        2: w = '0;
        3: w = '1;
        4: w = {SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
        5: w = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
        6: w = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
        default: w = {16'h0001, 16'hAAAA, 16'h5555, 16'hFFFE};
      endcase
      pending_words.push_back(w);
    end
    // Finish two packets at reset settings
    repeat (87) begin
      w.s0_re = rand_sample();
      w.s0_im = rand_sample();
      w.s1_re = rand_sample();
      w.s1_im = rand_sample();
      pending_words.push_back(w);
    end
    settings++;
    run_phase(1'b0, 10'd2,    10'd0,   224, 1'b0, 1'b0);
    run_phase(1'b0, 10'd0,    10'd1,   112, 1'b0, 1'b0);  // zero pairs acts as one
    run_phase(1'b0, 10'd3,    10'h3F0, 168, 1'b0, 1'b0);  // ue -16 acts as -1
    run_phase(1'b1, 10'd1,    10'd2,   242, 1'b1, 1'b0);  // all pilots zero, no gaps
    run_phase(1'b1, 10'd2,    10'h3FF, 400, 1'b0, 1'b1);  // long receiver hold
    run_phase(1'b1, 10'd512,  10'd8,   250, 1'b0, 1'b0);
    run_phase(1'b0, 10'h3FF,  10'd15,  200, 1'b0, 1'b0);  // pairs clipped to max
    run_phase(1'b0, 10'd1,    10'h3FF, 112, 1'b0, 1'b0);
    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d subcarrier words, checked %0d result words over %0d settings",
             words_in, words_out, settings);
    $display("(both FFT sizes, pair counts 0 to 1023, UE select -16 to 15, %0d errors)",
             errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
